>>> hw/rtl/assert_macros.svh
// Assertion helper macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> hw/rtl/gcl_pkg.sv
package gcl_pkg;

   localparam int GRID_DEPTH = 256;
   localparam int COORD_WIDTH = 32;
   localparam int IDX_W = $clog2(GRID_DEPTH);
   localparam int WGT_W = 17;
   localparam int FRAC_STEPS = 16;
   localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;

   typedef enum logic [1:0] {
      FUNC_WRITE_X = 2'd0,
      FUNC_WRITE_Y = 2'd1,
      FUNC_LOCATE  = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_LOWER_X = 2'd0,
      CSR_UPPER_X = 2'd1,
      CSR_LOWER_Y = 2'd2,
      CSR_UPPER_Y = 2'd3
   } csr_index_type;

   // Queued command between front and back
   typedef struct packed {
      func_type                       func;
      logic [IDX_W-1:0]               entry_index;
      logic signed [COORD_WIDTH-1:0]  coord_x;
      logic signed [COORD_WIDTH-1:0]  coord_y;
   } cmd_type;

   typedef struct packed {
      logic [IDX_W-1:0]  cell_x;
      logic [IDX_W-1:0]  cell_y;
      logic [WGT_W-1:0]  weight_x;
      logic [WGT_W-1:0]  weight_y;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AXIS,
      ST_RD_LO,
      ST_CHK_LO,
      ST_CHK_HI,
      ST_BIS_RD,
      ST_BIS_CHK,
      ST_W_RD0,
      ST_W_RD1,
      ST_W_CHK,
      ST_DIV,
      ST_NEXT,
      ST_OUT
   } back_state_type;

endpackage

>>> hw/rtl/gcl_front.sv
// Accepts items, drops unused codes and queues the rest for the back end
module gcl_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_func,
   input  logic [7:0]                         req_entry_index,
   input  logic signed [31:0]                 req_coord_x,
   input  logic signed [31:0]                 req_coord_y,
   output logic                               q_valid,
   output gcl_pkg::cmd_type                   q_cmd,
   input  logic                               q_pop
);

   logic                q_count_ff, q_count_in;
   logic                q1_ff, q1_in;
   gcl_pkg::cmd_type    q0_ff, q0_in, q1d_ff, q1d_in;
   gcl_pkg::cmd_type    cmd;
   logic                push;

   // Two-entry queue: q0 is the head
   assign req_stall = q1_ff;
   assign push = req_valid && !req_stall &&
                 (gcl_pkg::func_type'(req_func) != gcl_pkg::FUNC_NONE);

   always_comb begin
      cmd.func        = gcl_pkg::func_type'(req_func);
      cmd.entry_index = req_entry_index[gcl_pkg::IDX_W-1:0];
      cmd.coord_x     = req_coord_x;
      cmd.coord_y     = req_coord_y;
   end

   assign q_valid = q_count_ff;
   assign q_cmd   = q0_ff;

   always_comb begin
      q_count_in = q_count_ff;
      q1_in      = q1_ff;
      q0_in      = q0_ff;
      q1d_in     = q1d_ff;
      if (q_pop) begin
         // advance head
         q0_in      = q1_ff ? q1d_ff : cmd;
         q_count_in = q1_ff || push;
         q1_in      = 1'b0;
      end else if (push) begin
         if (!q_count_ff) begin
            q0_in      = cmd;
            q_count_in = 1'b1;
         end else begin
            q1d_in = cmd;
            q1_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_count_ff <= 1'b0;
         q1_ff      <= 1'b0;
      end else begin
         q_count_ff <= q_count_in;
         q1_ff      <= q1_in;
      end
      q0_ff  <= q0_in;
      q1d_ff <= q1d_in;
   end

endmodule

>>> hw/rtl/gcl_back.sv
// Executes table writes and locate queries one at a time
module gcl_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  gcl_pkg::cmd_type    q_cmd,
   output logic                q_pop,
   input  logic [7:0]          lower_x,
   input  logic [7:0]          upper_x,
   input  logic [7:0]          lower_y,
   input  logic [7:0]          upper_y,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_cell_x,
   output logic [7:0]          rsp_cell_y,
   output logic [16:0]         rsp_weight_x,
   output logic [16:0]         rsp_weight_y
);

   localparam int IW = gcl_pkg::IDX_W;
   localparam int CW = gcl_pkg::COORD_WIDTH;

   logic signed [CW-1:0] x_mem [gcl_pkg::GRID_DEPTH];
   logic signed [CW-1:0] y_mem [gcl_pkg::GRID_DEPTH];
   logic signed [CW-1:0] rd_x_ff, rd_y_ff;
   logic [IW-1:0]        rd_addr;

   gcl_pkg::back_state_type st_ff, st_in;
   gcl_pkg::cmd_type        cmd_ff, cmd_in;
   logic                    axis_ff, axis_in;
   logic [IW:0]             lo_ff, lo_in, hi_ff, hi_in;
   logic [IW-1:0]           cell_ff, cell_in;
   logic signed [CW-1:0]    g0_ff, g0_in;
   logic [CW:0]             num_ff, num_in, den_ff, den_in;
   logic [gcl_pkg::WGT_W-1:0] q_ff, q_in;
   logic [4:0]              cnt_ff, cnt_in;
   gcl_pkg::result_type     res_ff, res_in;
   logic                    out_ff, out_in;

   logic signed [CW-1:0] p, rd_data;
   logic [IW:0]          lo_cfg, hi_cfg, mid;
   logic [CW:0]          diff;

   assign p       = axis_ff ? cmd_ff.coord_y : cmd_ff.coord_x;
   assign rd_data = axis_ff ? rd_y_ff : rd_x_ff;
   assign lo_cfg  = {1'b0, axis_ff ? lower_y : lower_x};
   assign hi_cfg  = {1'b0, axis_ff ? upper_y : upper_x};
   assign mid     = (lo_ff + hi_ff) >> 1;
   assign diff    = den_ff - num_ff;

   // Table memories: write from queued command, registered read
   always_ff @(posedge clock) begin
      if (st_ff == gcl_pkg::ST_IDLE && q_valid) begin
         if (q_cmd.func == gcl_pkg::FUNC_WRITE_X) x_mem[q_cmd.entry_index] <= q_cmd.coord_x;
         if (q_cmd.func == gcl_pkg::FUNC_WRITE_Y) y_mem[q_cmd.entry_index] <= q_cmd.coord_x;
      end
      rd_x_ff <= x_mem[rd_addr];
      rd_y_ff <= y_mem[rd_addr];
   end

   // Sequencer
   always_comb begin
      st_in   = st_ff;
      cmd_in  = cmd_ff;
      axis_in = axis_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      cell_in = cell_ff;
      g0_in   = g0_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      res_in  = res_ff;
      out_in  = out_ff;
      q_pop   = 1'b0;
      rd_addr = lo_ff[IW-1:0];
      if (out_ff && !rsp_stall) out_in = 1'b0;
      unique case (st_ff)
         gcl_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               if (q_cmd.func == gcl_pkg::FUNC_LOCATE) begin
                  axis_in = 1'b0;
                  st_in   = gcl_pkg::ST_AXIS;
               end
            end
         end
         gcl_pkg::ST_AXIS: begin
            lo_in = lo_cfg;
            hi_in = hi_cfg;
            st_in = gcl_pkg::ST_RD_LO;
         end
         gcl_pkg::ST_RD_LO: begin
            rd_addr = lo_ff[IW-1:0];
            st_in   = gcl_pkg::ST_CHK_LO;
         end
         gcl_pkg::ST_CHK_LO: begin
            rd_addr = hi_ff[IW-1:0];
            if (!(rd_data < p) || hi_ff <= lo_ff) begin
               cell_in = lo_ff[IW-1:0];
               st_in   = gcl_pkg::ST_W_RD0;
            end else begin
               st_in = gcl_pkg::ST_CHK_HI;
            end
         end
         gcl_pkg::ST_CHK_HI: begin
            if (!(p < rd_data)) begin
               cell_in = IW'(hi_ff - 1'b1);
               st_in   = gcl_pkg::ST_W_RD0;
            end else begin
               st_in = gcl_pkg::ST_BIS_RD;
            end
         end
         gcl_pkg::ST_BIS_RD: begin
            rd_addr = mid[IW-1:0];
            if (hi_ff - lo_ff > 1) st_in = gcl_pkg::ST_BIS_CHK;
            else begin
               cell_in = lo_ff[IW-1:0];
               st_in   = gcl_pkg::ST_W_RD0;
            end
         end
         gcl_pkg::ST_BIS_CHK: begin
            if (p < rd_data) hi_in = mid;
            else lo_in = mid;
            st_in = gcl_pkg::ST_BIS_RD;
         end
         gcl_pkg::ST_W_RD0: begin
            rd_addr = cell_ff;
            st_in   = gcl_pkg::ST_W_RD1;
         end
         gcl_pkg::ST_W_RD1: begin
            rd_addr = IW'(cell_ff + 1'b1);
            g0_in   = rd_data;
            st_in   = gcl_pkg::ST_W_CHK;
         end
         gcl_pkg::ST_W_CHK: begin
            num_in = (CW+1)'(p) - (CW+1)'(g0_ff);
            den_in = (CW+1)'(rd_data) - (CW+1)'(g0_ff);
            q_in   = '0;
            cnt_in = '0;
            if (!(g0_ff < p)) st_in = gcl_pkg::ST_NEXT;
            else if (!(p < rd_data)) begin
               q_in  = gcl_pkg::WGT_ONE;
               st_in = gcl_pkg::ST_NEXT;
            end else st_in = gcl_pkg::ST_DIV;
         end
         gcl_pkg::ST_DIV: begin
            // one quotient bit per cycle; num < den stays true
            if (num_ff >= diff) begin
               num_in = num_ff - diff;
               q_in   = {q_ff[gcl_pkg::WGT_W-2:0], 1'b1};
            end else begin
               num_in = num_ff << 1;
               q_in   = {q_ff[gcl_pkg::WGT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'(gcl_pkg::FRAC_STEPS - 1)) st_in = gcl_pkg::ST_NEXT;
         end
         gcl_pkg::ST_NEXT: begin
            if (!axis_ff) begin
               res_in.cell_x   = cell_ff;
               res_in.weight_x = q_ff;
               axis_in = 1'b1;
               st_in   = gcl_pkg::ST_AXIS;
            end else begin
               res_in.cell_y   = cell_ff;
               res_in.weight_y = q_ff;
               st_in = gcl_pkg::ST_OUT;
            end
         end
         gcl_pkg::ST_OUT: begin
            // hold until the output register is free
            if (!out_ff || !rsp_stall) begin
               out_in = 1'b1;
               st_in  = gcl_pkg::ST_IDLE;
            end
         end
         default: st_in = gcl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= gcl_pkg::ST_IDLE;
         out_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         out_ff <= out_in;
      end
      cmd_ff  <= cmd_in;
      axis_ff <= axis_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      cell_ff <= cell_in;
      g0_ff   <= g0_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
   end

   // Output register keeps the result while the receiver stalls
   gcl_pkg::result_type out_data_ff, out_data_in;
   assign out_data_in = (st_ff == gcl_pkg::ST_OUT && out_in && !(out_ff && rsp_stall))
                        ? res_ff : out_data_ff;
   always_ff @(posedge clock) out_data_ff <= out_data_in;

   assign rsp_valid    = out_ff;
   assign rsp_cell_x   = out_data_ff.cell_x;
   assign rsp_cell_y   = out_data_ff.cell_y;
   assign rsp_weight_x = out_data_ff.weight_x;
   assign rsp_weight_y = out_data_ff.weight_y;

endmodule

>>> hw/rtl/grid_cell_locate_bilinear_core.sv
// Grid cell locator with bilinear weights.
// Request channel (req_valid/req_stall): func, entry_index, coord_x, coord_y.
//   func 0/1 writes coord_x into the x/y grid table at entry_index; no result.
//   func 2 locates (coord_x, coord_y); func 3 is dropped.
// Result channel (rsp_valid/rsp_stall): cell_x, cell_y, weight_x, weight_y,
//   weights unsigned Q1.16 with 65536 meaning 1.0.
// Config channel (csr_valid/csr_ready): registers 0..3 = lower_x, upper_x,
//   lower_y, upper_y; always ready; write only while idle.
// A two-entry queue decouples acceptance from the sequencer. A table write
//   is written from the queue head while the sequencer is idle, one per
//   cycle. A locate runs per axis: load the bounds and check the ends,
//   bisect (up to 8 steps), read the two cell entries, run restoring
//   division over the 16 fraction bits when the weight is fractional, then
//   store. rsp_valid rises once both axes are done; the sequencer takes no
//   new item until the result is in the output register.
// The result waits in an output register while rsp_stall is high; the
//   sequencer then holds, and the queue fills and raises req_stall.
// Reset empties the queue and output, and restores the config registers;
//   table contents are undefined until written.
module grid_cell_locate_bilinear_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_func,
   input  logic [7:0]   req_entry_index,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_cell_x,
   output logic [7:0]   rsp_cell_y,
   output logic [16:0]  rsp_weight_x,
   output logic [16:0]  rsp_weight_y,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_data
);

   logic             q_valid, q_pop;
   gcl_pkg::cmd_type q_cmd;
   logic [7:0] lower_x_ff, upper_x_ff, lower_y_ff, upper_y_ff;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_x_ff <= 8'd0;
         upper_x_ff <= 8'd255;
         lower_y_ff <= 8'd0;
         upper_y_ff <= 8'd255;
      end else if (csr_valid) begin
         unique case (gcl_pkg::csr_index_type'(csr_index))
            gcl_pkg::CSR_LOWER_X: lower_x_ff <= csr_data;
            gcl_pkg::CSR_UPPER_X: upper_x_ff <= csr_data;
            gcl_pkg::CSR_LOWER_Y: lower_y_ff <= csr_data;
            gcl_pkg::CSR_UPPER_Y: upper_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   gcl_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_func, .req_entry_index,
      .req_coord_x, .req_coord_y, .q_valid, .q_cmd, .q_pop
   );

   gcl_back u_back (
      .clock, .reset, .q_valid, .q_cmd, .q_pop,
      .lower_x(lower_x_ff), .upper_x(upper_x_ff),
      .lower_y(lower_y_ff), .upper_y(upper_y_ff),
      .rsp_valid, .rsp_stall, .rsp_cell_x, .rsp_cell_y, .rsp_weight_x, .rsp_weight_y
   );

endmodule

>>> hw/rtl/gcl_checker.sv
`include "assert_macros.svh"

// Port-level checks on the locator
module gcl_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input logic [16:0]  rsp_weight_x,
   input logic [16:0]  rsp_weight_y,
   input logic [7:0]   rsp_cell_x
);

   `ASSERT_IMPL(a_wx_range, clock, reset, rsp_valid, rsp_weight_x <= 17'h10000, "weight_x above one")
   `ASSERT_IMPL(a_wy_range, clock, reset, rsp_valid, rsp_weight_y <= 17'h10000, "weight_y above one")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_cell_x), "stalled result changed")
   `ASSERT_IMPL(a_stall_known, clock, reset, req_valid, !$isunknown(req_stall), "req_stall unknown")

endmodule

bind grid_cell_locate_bilinear_core gcl_checker u_gcl_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_weight_x, .rsp_weight_y, .rsp_cell_x
);
